/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent assertions of the glyph blitter checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/gbu_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph blitter package
// Command codes, the classified item passed from front to back and the font.
// ----------------------------------------------------------------------------
package gbu_pkg;

  localparam int unsigned FONT_COLS   = 5;
  localparam int unsigned FONT_ROWS   = 7;
  localparam int unsigned PAT_COLS    = 6;
  localparam int unsigned MAX_SCALE   = 4;
  localparam int unsigned PAT_W       = PAT_COLS * MAX_SCALE;
  localparam int unsigned PAT_IDX_W   = $clog2(PAT_W);
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned NUM_W       = 11;
  localparam int unsigned DIV_CNT_W   = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [7:0] GLYPH_FIRST  = 8'd32;
  localparam logic [7:0] GLYPH_LAST   = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [2:0] SCALE_MAX    = 3'd4;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_GLYPH = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STYLE_NORMAL = 2'd0,
    STYLE_NARROW = 2'd1,
    STYLE_BOLD   = 2'd2
  } style_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_PIXEL,
    OP_GLYPH,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PIXEL,
    BK_GLYPH,
    BK_DRAIN,
    BK_DIV,
    BK_RD0,
    BK_RD1,
    BK_ROUT
  } back_state_e;

  typedef logic [0:FONT_COLS-1][FONT_ROWS-1:0] font_t;
  typedef logic [0:PAT_COLS-1][FONT_ROWS-1:0]  gbu_cols_t;

  typedef struct packed {
    op_e               op;
    logic signed [9:0] x;
    logic signed [7:0] y;
    logic [7:0]        byte_idx;
    logic              pixel_on;
    logic [2:0]        scale;
    gbu_cols_t         cols;
  } gbu_item_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } gbu_q_status_t;

  function automatic font_t font_cols(input logic [5:0] idx);
    font_t f;
    case (idx)
      6'd13: f = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
      6'd16: f = {7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e};
      6'd17: f = {7'h00, 7'h42, 7'h7f, 7'h40, 7'h00};
      6'd18: f = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
      6'd19: f = {7'h21, 7'h41, 7'h45, 7'h4b, 7'h31};
      6'd20: f = {7'h18, 7'h14, 7'h12, 7'h7f, 7'h10};
      6'd21: f = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
      6'd22: f = {7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30};
      6'd23: f = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
      6'd24: f = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      6'd25: f = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1e};
      6'd26: f = {7'h00, 7'h24, 7'h00, 7'h24, 7'h00};
      6'd33: f = {7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e};
      6'd34: f = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h36};
      6'd35: f = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h22};
      6'd36: f = {7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c};
      6'd37: f = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h41};
      6'd38: f = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h01};
      6'd39: f = {7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a};
      6'd40: f = {7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f};
      6'd41: f = {7'h00, 7'h41, 7'h7f, 7'h41, 7'h00};
      6'd42: f = {7'h20, 7'h40, 7'h41, 7'h3f, 7'h01};
      6'd43: f = {7'h7f, 7'h08, 7'h14, 7'h22, 7'h41};
      6'd44: f = {7'h7f, 7'h40, 7'h40, 7'h40, 7'h40};
      6'd45: f = {7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f};
      6'd46: f = {7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f};
      6'd47: f = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e};
      6'd48: f = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h06};
      6'd49: f = {7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e};
      6'd50: f = {7'h7f, 7'h09, 7'h19, 7'h29, 7'h46};
      6'd51: f = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
      6'd52: f = {7'h01, 7'h01, 7'h7f, 7'h01, 7'h01};
      6'd53: f = {7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f};
      6'd54: f = {7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f};
      6'd55: f = {7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f};
      6'd56: f = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      6'd57: f = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
      6'd58: f = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

/* design/gbu_front.sv */
// ----------------------------------------------------------------------------
// Glyph blitter front end
// Accepts command beats, folds the character code, looks up the font and
// turns the style into a six column pattern and an effective scale.
// ----------------------------------------------------------------------------
module gbu_front (
  input  logic                  start_i,
  input  gbu_pkg::gbu_q_status_t q_status_i,
  input  logic [1:0]            cmd_i,
  input  logic signed [9:0]     x_pos_i,
  input  logic signed [7:0]     y_pos_i,
  input  logic [7:0]            char_code_i,
  input  logic [2:0]            glyph_scale_i,
  input  logic [1:0]            glyph_style_i,
  input  logic                  pixel_on_i,
  input  logic [7:0]            byte_index_i,
  output logic                  busy_o,
  output logic                  push_o,
  output gbu_pkg::gbu_item_t    item_o
);
  import gbu_pkg::*;

  logic [7:0] code_fold;
  logic [5:0] glyph_idx;
  font_t      font;
  gbu_cols_t  cols;
  logic [2:0] scale_eff;
  logic       draws;
  op_e        op;

  always_comb begin
    code_fold = char_code_i;
    if (char_code_i >= CHAR_LOWER_A && char_code_i <= CHAR_LOWER_Z) begin
      code_fold = char_code_i - CASE_OFFSET;
    end
    if (code_fold >= GLYPH_FIRST && code_fold <= GLYPH_LAST) begin
      glyph_idx = 6'(code_fold - GLYPH_FIRST);
    end else begin
      glyph_idx = '0;
    end
  end

  assign font = font_cols(glyph_idx);

  always_comb begin
    cols      = '0;
    scale_eff = 3'd1;
    draws     = 1'b1;
    case (style_e'(glyph_style_i))
      STYLE_NORMAL: begin
        for (int c = 0; c < FONT_COLS; c++) begin
          cols[c] = font[c];
        end
        if (glyph_scale_i > SCALE_MAX) begin
          scale_eff = SCALE_MAX;
        end else if (glyph_scale_i != 3'd0) begin
          scale_eff = glyph_scale_i;
        end
      end
      STYLE_NARROW: begin
        for (int c = 0; c < FONT_COLS - 1; c++) begin
          cols[c] = font[c];
        end
      end
      STYLE_BOLD: begin
        cols[0] = font[0];
        for (int c = 1; c < FONT_COLS; c++) begin
          cols[c] = font[c] | font[c-1];
        end
        cols[FONT_COLS] = font[FONT_COLS-1];
      end
      default: begin
        draws = 1'b0;
      end
    endcase
  end

  // A glyph that sets no pixel is dropped here.
  always_comb begin
    case (cmd_e'(cmd_i))
      CMD_CLEAR: op = OP_CLEAR;
      CMD_PIXEL: op = OP_PIXEL;
      CMD_GLYPH: op = (draws && cols != '0) ? OP_GLYPH : OP_NOP;
      CMD_READ:  op = OP_READ;
      default:   op = OP_NOP;
    endcase
  end

  assign busy_o = q_status_i.full;
  assign push_o = start_i && !q_status_i.full;

  always_comb begin
    item_o          = '0;
    item_o.op       = op;
    item_o.x        = x_pos_i;
    item_o.y        = y_pos_i;
    item_o.byte_idx = byte_index_i;
    item_o.pixel_on = pixel_on_i;
    item_o.scale    = scale_eff;
    item_o.cols     = cols;
  end

endmodule

/* design/gbu_fifo.sv */
// ----------------------------------------------------------------------------
// Glyph blitter command queue
// Two entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module gbu_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  gbu_pkg::gbu_item_t     item_i,
  input  logic                   pop_i,
  output gbu_pkg::gbu_q_status_t status_o,
  output gbu_pkg::gbu_item_t     head_o
);
  import gbu_pkg::*;

  gbu_item_t         entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign status_o.full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.not_empty = (cnt_q != '0);
  assign head_o             = entry_q[rd_ptr_q];

endmodule

/* design/gbu_back.sv */
// ----------------------------------------------------------------------------
// Glyph blitter back end
// Owns the frame store and carries out clear, pixel write, glyph draw and
// byte read, one row read-modify-write per cycle.
// ----------------------------------------------------------------------------
module gbu_back #(
  parameter int unsigned PANEL_WIDTH  = 24,
  parameter int unsigned PANEL_HEIGHT = 67
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  gbu_pkg::gbu_item_t item_i,
  output logic               pop_o,
  output logic [7:0]         read_data_o,
  output logic               read_valid_o
);
  import gbu_pkg::*;

  localparam int unsigned ROW_W = $clog2(PANEL_HEIGHT);
  localparam int unsigned COL_W = $clog2(PANEL_WIDTH);
  localparam logic [NUM_W-1:0] RECIP = NUM_W'((1 << NUM_W) / PANEL_WIDTH);

  back_state_e state_q, state_d;

  logic [PANEL_WIDTH-1:0]  frame_q [PANEL_HEIGHT];
  logic [PANEL_HEIGHT-1:0] row_vld_q;
  logic [PANEL_WIDTH-1:0]  rd_data_q;
  logic                    rd_vld_q;
  logic [PANEL_WIDTH-1:0]  rd_eff;

  logic                   wr_pend_q;
  logic [ROW_W-1:0]       wr_row_q;
  logic [PANEL_WIDTH-1:0] wr_mask_q;
  logic                   wr_set_q;
  logic [PANEL_WIDTH-1:0] wr_data;

  logic [2:0]        row_q, row_d;
  logic [1:0]        dy_q, dy_d;
  logic signed [9:0] ty_q, ty_d;
  logic [1:0]        scale_m1;
  logic              glyph_last;

  logic [NUM_W-1:0]     num_q, num_d;
  logic [COL_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]     num_in;
  logic [2*NUM_W-1:0]   q_prod;
  logic [NUM_W-1:0]     q_times_w;
  logic [NUM_W-1:0]     r_est;
  logic                 r_ge;

  logic [PANEL_WIDTH-1:0] row0_q;
  logic [7:0]             byte_val;
  logic [7:0]             read_data_q;
  logic                   read_valid_q;

  logic                   clr;
  logic                   rd_issue;
  logic                   wr_issue;
  logic                   rd_ok;
  logic signed [11:0]     row_s;
  logic [ROW_W-1:0]       rd_addr;
  logic [PANEL_WIDTH-1:0] mask_sel;
  logic                   set_sel;
  logic                   cap_row0;
  logic                   out_strobe;

  logic [PAT_COLS-1:0]    row_bits;
  logic [PAT_W-1:0]       pat;
  logic signed [11:0]     x_ext;
  logic signed [11:0]     rel [PANEL_WIDTH];
  logic [PANEL_WIDTH-1:0] glyph_mask;
  logic [PANEL_WIDTH-1:0] pix_mask;
  logic [COL_W:0]         bit_col [BYTE_BITS];
  logic [COL_W:0]         bit_wrap [BYTE_BITS];

  assign rd_eff  = rd_vld_q ? rd_data_q : '0;
  assign wr_data = wr_set_q ? (rd_eff | wr_mask_q) : (rd_eff & ~wr_mask_q);

  // Glyph row pattern, magnified along the row.
  always_comb begin
    for (int c = 0; c < PAT_COLS; c++) begin
      row_bits[c] = item_i.cols[c][row_q];
    end
    pat = '0;
    case (item_i.scale)
      3'd2: for (int j = 0; j < PAT_COLS * 2; j++) pat[j] = row_bits[j / 2];
      3'd3: for (int j = 0; j < PAT_COLS * 3; j++) pat[j] = row_bits[j / 3];
      3'd4: for (int j = 0; j < PAT_COLS * 4; j++) pat[j] = row_bits[j / 4];
      default: for (int j = 0; j < PAT_COLS; j++) pat[j] = row_bits[j];
    endcase
  end

  assign x_ext = {{2{item_i.x[9]}}, item_i.x};

  always_comb begin
    for (int px = 0; px < PANEL_WIDTH; px++) begin
      rel[px]        = 12'(px) - x_ext;
      glyph_mask[px] = !rel[px][11] && (rel[px] < 12'(PAT_W)) && pat[rel[px][PAT_IDX_W-1:0]];
      pix_mask[px]   = (rel[px] == 12'sd0);
    end
  end

  assign scale_m1   = 2'(item_i.scale - 3'd1);
  assign glyph_last = (row_q == 3'(FONT_ROWS - 1)) && (dy_q == scale_m1);

  // Division of the first pixel number by the panel width: a reciprocal
  // estimate that is at most one low, then one correcting subtract.
  assign num_in    = {item_i.byte_idx, 3'b000};
  assign q_prod    = (2*NUM_W)'(num_in) * (2*NUM_W)'(RECIP);
  assign q_times_w = num_q * NUM_W'(PANEL_WIDTH);
  assign r_est     = num_in - q_times_w;
  assign r_ge      = (r_est >= NUM_W'(PANEL_WIDTH));

  always_comb begin
    for (int k = 0; k < BYTE_BITS; k++) begin
      bit_col[k]  = (COL_W+1)'(rem_q) + (COL_W+1)'(k);
      bit_wrap[k] = bit_col[k] - (COL_W+1)'(PANEL_WIDTH);
      if (bit_col[k] < (COL_W+1)'(PANEL_WIDTH)) begin
        byte_val[BYTE_BITS-1-k] = row0_q[bit_col[k][COL_W-1:0]];
      end else begin
        byte_val[BYTE_BITS-1-k] = rd_eff[bit_wrap[k][COL_W-1:0]];
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    clr        = 1'b0;
    rd_issue   = 1'b0;
    wr_issue   = 1'b0;
    row_s      = '0;
    mask_sel   = glyph_mask;
    set_sel    = 1'b1;
    cap_row0   = 1'b0;
    out_strobe = 1'b0;
    row_d      = row_q;
    dy_d       = dy_q;
    ty_d       = ty_q;
    num_d      = num_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          case (item_i.op)
            OP_CLEAR: begin
              clr   = 1'b1;
              pop_o = 1'b1;
            end
            OP_PIXEL: state_d = BK_PIXEL;
            OP_GLYPH: begin
              row_d   = '0;
              dy_d    = '0;
              ty_d    = {{2{item_i.y[7]}}, item_i.y};
              state_d = BK_GLYPH;
            end
            OP_READ: begin
              num_d   = {item_i.byte_idx, 3'b000};
              rem_d   = '0;
              cnt_d   = '0;
              state_d = BK_DIV;
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      BK_PIXEL: begin
        rd_issue = 1'b1;
        wr_issue = 1'b1;
        row_s    = {{4{item_i.y[7]}}, item_i.y};
        mask_sel = pix_mask;
        set_sel  = item_i.pixel_on;
        state_d  = BK_DRAIN;
      end
      BK_GLYPH: begin
        rd_issue = 1'b1;
        wr_issue = 1'b1;
        row_s    = {{2{ty_q[9]}}, ty_q};
        ty_d     = ty_q + 10'sd1;
        if (dy_q == scale_m1) begin
          dy_d  = '0;
          row_d = row_q + 3'd1;
        end else begin
          dy_d = dy_q + 2'd1;
        end
        if (glyph_last) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        pop_o   = 1'b1;
        state_d = BK_IDLE;
      end
      BK_DIV: begin
        if (cnt_q == '0) begin
          num_d = NUM_W'(q_prod >> NUM_W);
          cnt_d = cnt_q + DIV_CNT_W'(1);
        end else begin
          num_d   = num_q + NUM_W'(r_ge);
          rem_d   = r_ge ? COL_W'(r_est - NUM_W'(PANEL_WIDTH)) : COL_W'(r_est);
          state_d = BK_RD0;
        end
      end
      BK_RD0: begin
        rd_issue = 1'b1;
        row_s    = $signed({1'b0, num_q});
        state_d  = BK_RD1;
      end
      BK_RD1: begin
        rd_issue = 1'b1;
        row_s    = $signed({1'b0, num_q} + 12'd1);
        cap_row0 = 1'b1;
        state_d  = BK_ROUT;
      end
      BK_ROUT: begin
        out_strobe = 1'b1;
        pop_o      = 1'b1;
        state_d    = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign rd_ok   = rd_issue && !row_s[11] && (row_s < $signed(12'(PANEL_HEIGHT)));
  assign rd_addr = rd_ok ? row_s[ROW_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      row_vld_q    <= '0;
      rd_vld_q     <= 1'b0;
      wr_pend_q    <= 1'b0;
      read_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr) begin
        row_vld_q <= '0;
      end else if (wr_pend_q) begin
        row_vld_q[wr_row_q] <= 1'b1;
      end
      rd_vld_q     <= rd_ok && row_vld_q[rd_addr];
      wr_pend_q    <= wr_issue && rd_ok;
      read_valid_q <= out_strobe;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      frame_q[wr_row_q] <= wr_data;
    end
    rd_data_q <= frame_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    dy_q      <= dy_d;
    ty_q      <= ty_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    wr_row_q  <= rd_addr;
    wr_mask_q <= mask_sel;
    wr_set_q  <= set_sel;
    if (cap_row0) begin
      row0_q <= rd_eff;
    end
    if (out_strobe) begin
      read_data_q <= byte_val;
    end
  end

  assign read_data_o  = read_data_q;
  assign read_valid_o = read_valid_q;

endmodule

/* design/glyph_blitter_1bpp_unit.sv */
// ----------------------------------------------------------------------------
// Glyph blitter, 1 bit per pixel
// Frame store with a 5x7 font generator: clear, pixel write, glyph draw and
// packed byte read.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  command   in         start high, busy low      cmd_i .. byte_index_i
//  result    out        read_valid_o, one cycle   read_data_o
//
//  Commands pass through a two beat queue, so start is taken while the back
//  end works. Clear is done straight from idle; a pixel write reads, modifies
//  and writes back one row; a glyph draw does one row read-modify-write of
//  the frame store per cycle; a byte read uses a two step reciprocal division
//  by the width, then reads two rows and then returns the byte.
//  Reset clears the per-row valid bits at once; there is no clearing pass.
//  The receiver cannot stall; busy rises only when the queue is full.
module glyph_blitter_1bpp_unit #(
  parameter int unsigned PANEL_WIDTH  = 24,
  parameter int unsigned PANEL_HEIGHT = 67
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd_i,
  input  logic signed [9:0] x_pos_i,
  input  logic signed [7:0] y_pos_i,
  input  logic [7:0]        char_code_i,
  input  logic [2:0]        glyph_scale_i,
  input  logic [1:0]        glyph_style_i,
  input  logic              pixel_on_i,
  input  logic [7:0]        byte_index_i,
  output logic [7:0]        read_data_o,
  output logic              read_valid_o
);
  import gbu_pkg::*;

  gbu_q_status_t q_status;
  gbu_item_t     front_item;
  gbu_item_t     head_item;
  logic          push;
  logic          pop;

  gbu_front u_front (
    .start_i       (start),
    .q_status_i    (q_status),
    .cmd_i         (cmd_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .char_code_i   (char_code_i),
    .glyph_scale_i (glyph_scale_i),
    .glyph_style_i (glyph_style_i),
    .pixel_on_i    (pixel_on_i),
    .byte_index_i  (byte_index_i),
    .busy_o        (busy),
    .push_o        (push),
    .item_o        (front_item)
  );

  gbu_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .status_o (q_status),
    .head_o   (head_item)
  );

  gbu_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_status.not_empty),
    .item_i       (head_item),
    .pop_o        (pop),
    .read_data_o  (read_data_o),
    .read_valid_o (read_valid_o)
  );

endmodule

/* design/gbu_checker.sv */
// ----------------------------------------------------------------------------
// Glyph blitter checker
// Port level assertions on the glyph blitter, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [7:0] read_data_o,
  input logic       read_valid_o
);

  // The queue only fills through an accepted beat.
  `ASSERT_RST(busy_rise_a, clk_i, rst_ni, $rose(busy) |-> $past(start && !busy), "busy rose without an accepted beat")

  // A byte read passes through division, two row reads and an output state, so results never come back to back.
  `ASSERT_RST(res_gap_a, clk_i, rst_ni, read_valid_o |=> !read_valid_o, "results on adjacent cycles")

  // Never-written rows read as zero, so a result is always known.
  `ASSERT_RST(res_known_a, clk_i, rst_ni, read_valid_o |-> !$isunknown(read_data_o), "unknown result data")

  `ASSERT_ALWAYS(rst_quiet_a, clk_i, !rst_ni |=> (!busy && !read_valid_o), "activity during reset")

endmodule

bind glyph_blitter_1bpp_unit gbu_checker u_gbu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .read_data_o  (read_data_o),
  .read_valid_o (read_valid_o)
);

/* tb/glyph_frame_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph blitter frame checker
// Watches the command and result channels of the glyph blitter. It keeps its
// own 1-bit frame store and font, replays every accepted command on it, holds
// the packed bytes that reads must return and compares each result beat with
// the oldest of them.
// ----------------------------------------------------------------------------
module glyph_frame_checker #(
  parameter int PANEL_WIDTH  = 24,
  parameter int PANEL_HEIGHT = 67
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        cmd_i,
  input  logic signed [9:0] x_pos_i,
  input  logic signed [7:0] y_pos_i,
  input  logic [7:0]        char_code_i,
  input  logic [2:0]        glyph_scale_i,
  input  logic [1:0]        glyph_style_i,
  input  logic              pixel_on_i,
  input  logic [7:0]        byte_index_i,
  input  logic [7:0]        read_data_o,
  input  logic              read_valid_o,
  output int                errors_o,
  output int                pending_o
);
  import gbu_pkg::*;

  // Column-coded 5x7 font from space to Z, first column in the top byte.
  localparam logic [39:0] GLYPH_BITMAPS [0:58] = '{
    40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0,
    40'h0, 40'h0, 40'h0, 40'h0808080808, 40'h0, 40'h0,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0024002400,
    40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0,
    40'h7e1111117e, 40'h7f49494936, 40'h3e41414122, 40'h7f4141221c,
    40'h7f49494941, 40'h7f09090901, 40'h3e4149497a, 40'h7f0808087f,
    40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906,
    40'h3e4151215e, 40'h7f09192946, 40'h4649494931, 40'h01017f0101,
    40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
    40'h0708700807, 40'h6151494543
  };

  logic [PANEL_WIDTH-1:0] frame_q [PANEL_HEIGHT];
  logic [7:0]             read_bytes_due [$];
  logic [7:0]             due_byte;
  int                     mismatches = 0;

  task automatic plot(input int x, input int y, input logic on);
    if (x >= 0 && x < PANEL_WIDTH && y >= 0 && y < PANEL_HEIGHT) begin
      frame_q[y][x] = on;
    end
  endtask

  task automatic draw_glyph(input int x, input int y, input logic [7:0] code,
                            input logic [2:0] scale, input logic [1:0] style);
    logic [7:0]  ch;
    logic [39:0] bitmap;
    logic [7:0]  column;
    int          mag;
    int          ncols;
    ch = code;
    if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ch = ch - CASE_OFFSET;
    if (ch < GLYPH_FIRST || ch > GLYPH_LAST) return;
    bitmap = GLYPH_BITMAPS[ch - GLYPH_FIRST];
    case (style)
      STYLE_NORMAL: begin
        if (scale == 0) mag = 1;
        else if (scale > SCALE_MAX) mag = int'(SCALE_MAX);
        else mag = int'(scale);
        ncols = FONT_COLS;
      end
      STYLE_NARROW: begin
        mag   = 1;
        ncols = FONT_COLS - 1;
      end
      STYLE_BOLD: begin
        mag   = 1;
        ncols = FONT_COLS;
      end
      default: return;
    endcase
    for (int col = 0; col < ncols; col++) begin
      column = bitmap[39 - 8 * col -: 8];
      for (int row = 0; row < FONT_ROWS; row++) begin
        if (column[row]) begin
          for (int dx = 0; dx < mag; dx++) begin
            for (int dy = 0; dy < mag; dy++) begin
              plot(x + col * mag + dx, y + row * mag + dy, 1'b1);
            end
          end
          if (style == STYLE_BOLD) plot(x + col + 1, y + row, 1'b1);
        end
      end
    end
  endtask

  function automatic logic [7:0] packed_byte(input logic [7:0] idx);
    logic [7:0] b;
    int         p;
    b = '0;
    for (int k = 0; k < 8; k++) begin
      p = int'(idx) * 8 + k;
      if (p < PANEL_WIDTH * PANEL_HEIGHT) b[7-k] = frame_q[p / PANEL_WIDTH][p % PANEL_WIDTH];
    end
    return b;
  endfunction

  task automatic apply_command();
    case (cmd_e'(cmd_i))
      CMD_CLEAR: begin
        for (int r = 0; r < PANEL_HEIGHT; r++) frame_q[r] = '0;
      end
      CMD_PIXEL: plot(int'(x_pos_i), int'(y_pos_i), pixel_on_i);
      CMD_GLYPH: draw_glyph(int'(x_pos_i), int'(y_pos_i), char_code_i, glyph_scale_i,
                            glyph_style_i);
      CMD_READ:  read_bytes_due.push_back(packed_byte(byte_index_i));
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < PANEL_HEIGHT; r++) frame_q[r] = '0;
      read_bytes_due.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (read_valid_o) begin
        if (read_bytes_due.size() == 0) begin
          mismatches++;
          $display("%0t: read_data expected none, actual %02h", $time, read_data_o);
        end else begin
          due_byte = read_bytes_due.pop_front();
          if (read_data_o !== due_byte) begin
            mismatches++;
            $display("%0t: read_data expected %02h, actual %02h",
                     $time, due_byte, read_data_o);
          end
        end
      end
      if (start && !busy) apply_command();
      pending_o <= read_bytes_due.size();
      errors_o  <= mismatches;
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph blitter testbench
// Drives directed and random commands into the glyph blitter in bursts with
// random gaps: pixel writes, glyph strings in every style and scale, clears
// and byte reads across and beyond the panel. A separate checker predicts and
// compares the read beats; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import gbu_pkg::*;

  localparam int ITEM_TARGET    = 1000;
  localparam int STALL_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 64;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        cmd_i = '0;
  logic signed [9:0] x_pos_i = '0;
  logic signed [7:0] y_pos_i = '0;
  logic [7:0]        char_code_i = '0;
  logic [2:0]        glyph_scale_i = '0;
  logic [1:0]        glyph_style_i = '0;
  logic              pixel_on_i = 1'b0;
  logic [7:0]        byte_index_i = '0;
  logic [7:0]        read_data_o;
  logic              read_valid_o;
  int                errors;
  int                pending;
  int                beats_sent = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  glyph_blitter_1bpp_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .char_code_i  (char_code_i),
    .glyph_scale_i(glyph_scale_i),
    .glyph_style_i(glyph_style_i),
    .pixel_on_i   (pixel_on_i),
    .byte_index_i (byte_index_i),
    .read_data_o  (read_data_o),
    .read_valid_o (read_valid_o)
  );

  glyph_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .char_code_i  (char_code_i),
    .glyph_scale_i(glyph_scale_i),
    .glyph_style_i(glyph_style_i),
    .pixel_on_i   (pixel_on_i),
    .byte_index_i (byte_index_i),
    .read_data_o  (read_data_o),
    .read_valid_o (read_valid_o),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || read_valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic issue(input cmd_e cmd, input int x, input int y, input int code,
                       input int scale, input int style, input int on, input int idx);
    @(negedge clk_i);
    cmd_i         <= cmd;
    x_pos_i       <= x[9:0];
    y_pos_i       <= y[7:0];
    char_code_i   <= code[7:0];
    glyph_scale_i <= scale[2:0];
    glyph_style_i <= style[1:0];
    pixel_on_i    <= on[0];
    byte_index_i  <= idx[7:0];
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    beats_sent++;
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 25));
    end
  endtask

  task automatic random_command();
    int pick;
    int x;
    int y;
    int code;
    pick = $urandom_range(0, 99);
    x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 39) - 8;
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 82) - 8;
    case ($urandom_range(0, 6))
      0:       code = $urandom_range(0, 255);
      1:       code = $urandom_range(97, 122);
      default: code = $urandom_range(32, 90);
    endcase
    if (pick < 2) begin
      issue(CMD_CLEAR, x, y, code, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 35) begin
      issue(CMD_PIXEL, x, y, code, $urandom, $urandom, $urandom_range(0, 9) < 7,
            $urandom);
    end else if (pick < 65) begin
      issue(CMD_GLYPH, x, y, code,
            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
            ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2), $urandom, $urandom);
    end else begin
      issue(CMD_READ, x, y, code, $urandom, $urandom, $urandom,
            ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 200));
    end
    pace();
  endtask

  task automatic glyph_string();
    int scale;
    int style;
    int x;
    int y;
    int step;
    int last_row;
    scale = $urandom_range(1, 4);
    style = $urandom_range(0, 2);
    x     = $urandom_range(0, 6) - 3;
    y     = $urandom_range(0, 62) - 2;
    step  = (style == STYLE_NORMAL) ? 6 * scale : 6;
    if ($urandom_range(0, 1) == 0) begin
      issue(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      pace();
    end
    repeat ($urandom_range(3, 5)) begin
      issue(CMD_GLYPH, x, y,
            ($urandom_range(0, 3) == 0) ? $urandom_range(97, 122) : $urandom_range(32, 90),
            scale, style, $urandom, $urandom);
      pace();
      x += step;
    end
    last_row = y + ((7 * scale < 10) ? 7 * scale : 10);
    for (int row = (y < 0) ? 0 : y; row <= last_row && row < 67; row++) begin
      for (int b = 0; b < 3; b++) begin
        issue(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              row * 3 + b);
        pace();
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    issue(CMD_READ,  0, 0, 0, 0, 0, 0, 0);
    issue(CMD_READ,  0, 0, 0, 0, 0, 0, 255);
    issue(CMD_PIXEL, 0, 0, 0, 0, 0, 1, 0);
    issue(CMD_PIXEL, 23, 66, 0, 0, 0, 1, 0);
    issue(CMD_PIXEL, -1, 0, 0, 0, 0, 1, 0);
    issue(CMD_PIXEL, 24, 0, 0, 0, 0, 1, 0);
    issue(CMD_PIXEL, 0, 67, 0, 0, 0, 1, 0);
    issue(CMD_PIXEL, -512, -128, 0, 0, 0, 1, 0);
    issue(CMD_PIXEL, 511, 127, 0, 0, 0, 1, 0);
    issue(CMD_READ,  0, 0, 0, 0, 0, 0, 0);
    issue(CMD_READ,  0, 0, 0, 0, 0, 0, 200);
    issue(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0);
    issue(CMD_READ,  0, 0, 0, 0, 0, 0, 0);
    issue(CMD_GLYPH, 0, 0, "0", 1, STYLE_NORMAL, 0, 0);
    issue(CMD_GLYPH, 6, 0, "a", 1, STYLE_NARROW, 0, 0);
    issue(CMD_GLYPH, 20, 10, "W", 1, STYLE_BOLD, 0, 0);
    issue(CMD_GLYPH, 0, 20, "M", 0, STYLE_NORMAL, 0, 0);
    issue(CMD_GLYPH, 2, 40, "B", 7, STYLE_NORMAL, 0, 0);
    issue(CMD_GLYPH, 12, 0, "Z", 1, 3, 0, 0);
    issue(CMD_GLYPH, 12, 8, 200, 1, STYLE_NORMAL, 0, 0);
    issue(CMD_GLYPH, 18, 8, 31, 1, STYLE_NORMAL, 0, 0);
    issue(CMD_GLYPH, -3, -2, "-", 2, STYLE_NORMAL, 0, 0);
    issue(CMD_READ,  0, 0, 0, 0, 0, 0, 0);
    issue(CMD_READ,  0, 0, 0, 0, 0, 0, 32);
    issue(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    issue(CMD_READ,  0, 0, 0, 0, 0, 0, 0);
    wait_drained();

    while (beats_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) glyph_string();
      else random_command();
      if ($urandom_range(0, 199) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/gbu_pkg.sv
design/gbu_front.sv
design/gbu_fifo.sv
design/gbu_back.sv
design/glyph_blitter_1bpp_unit.sv
design/gbu_checker.sv
tb/glyph_frame_checker.sv
tb/tb.sv
